[hw/rtl/assert_macros.svh]
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

[hw/rtl/rws_pkg.sv]
`timescale 1ns / 1ps

package rws_pkg;

   // Table geometry and field widths
   localparam int MAX_ENTRIES  = 256;
   localparam int ENTRY_BITS   = 8;
   localparam int SIZE_BITS    = 9;
   localparam int FITNESS_BITS = 32;
   localparam int RANDOM_BITS  = 32;
   localparam int SPAN_BITS    = 41;
   localparam int ACC_BITS     = 44;
   localparam int COUNT_BITS   = 17;
   localparam int LIMIT_BITS   = 16;
   localparam int CSR_IDX_BITS = 2;
   localparam int CSR_DAT_BITS = 16;

   // Request opcodes
   localparam logic [1:0] OP_LOAD   = 2'd0;
   localparam logic [1:0] OP_START  = 2'd1;
   localparam logic [1:0] OP_SELECT = 2'd2;

   // Response status codes
   localparam logic [1:0] STATUS_OK         = 2'd0;
   localparam logic [1:0] STATUS_DEGENERATE = 2'd1;
   localparam logic [1:0] STATUS_LAP        = 2'd2;

   // Register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_POP_SIZE = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_REBASED  = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_LIMIT    = 2'd2;

   // Control from the sequencer to the fitness table
   typedef struct packed {
      logic                  wr_en;
      logic [ENTRY_BITS-1:0] wr_addr;
      logic [ENTRY_BITS-1:0] rd_addr;
   } ram_ctl_type;

endpackage

[hw/rtl/rws_fitness_ram.sv]
`timescale 1ns / 1ps

module rws_fitness_ram (
   input  logic                                clock,
   input  rws_pkg::ram_ctl_type                ctl,
   input  logic [rws_pkg::FITNESS_BITS-1:0]    wr_data,
   output logic [rws_pkg::FITNESS_BITS-1:0]    rd_data
);

   logic [rws_pkg::FITNESS_BITS-1:0] mem [rws_pkg::MAX_ENTRIES];
   logic [rws_pkg::FITNESS_BITS-1:0] rd_data_ff;

   // One write port, one registered read port
   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[ctl.wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[ctl.rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/roulette_wheel_selector_top.sv]
`timescale 1ns / 1ps
// Channel   Direction  Handshake             Payload
// req_      in         start / busy          op, entry_index, fitness_value,
//                                            random_fraction, start_marker
// rsp_      out        valid strobe          selected_index, done_res, status
// csr_      in         valid / ready         index, data
//
// Load, op 3, size-zero starts and degenerate selects answer the cycle after acceptance.
// A start makes one table read and one accumulate per entry through the single read
// port and the shared adder, in rebased mode after reading the last entry as base.
// Select walks 1 to size entries, one per cycle. Reset is synchronous and resets all
// but the datapath registers (pop size to 1); the table is undefined until loaded.
// The response strobe lasts one cycle and cannot be stalled; csr_ready is always high.

`include "assert_macros.svh"

module roulette_wheel_selector_top (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    start,
   output logic                                    busy,
   input  logic [1:0]                              req_op,
   input  logic [rws_pkg::ENTRY_BITS-1:0]          req_entry_index,
   input  logic signed [rws_pkg::FITNESS_BITS-1:0] req_fitness_value,
   input  logic [rws_pkg::RANDOM_BITS-1:0]         req_random_fraction,
   input  logic [rws_pkg::ENTRY_BITS-1:0]          req_start_marker,
   output logic                                    rsp_valid,
   output logic [rws_pkg::ENTRY_BITS-1:0]          rsp_selected_index,
   output logic                                    rsp_done_res,
   output logic [1:0]                              rsp_status,
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [rws_pkg::CSR_IDX_BITS-1:0]        csr_index,
   input  logic [rws_pkg::CSR_DAT_BITS-1:0]        csr_data
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_BASE,
      ST_SUM,
      ST_MUL_LO,
      ST_MUL_HI,
      ST_WALK
   } state_type;

   localparam int AB = rws_pkg::ACC_BITS;
   localparam int FB = rws_pkg::FITNESS_BITS;
   localparam int SB = rws_pkg::SPAN_BITS;
   localparam int EB = rws_pkg::ENTRY_BITS;
   localparam int ZB = rws_pkg::SIZE_BITS;
   localparam int CB = rws_pkg::COUNT_BITS;
   localparam int RB = rws_pkg::RANDOM_BITS;

   state_type                        state_ff, state_in;
   logic [ZB-1:0]                    pop_ff, pop_in;
   logic                             rebased_ff, rebased_in;
   logic [rws_pkg::LIMIT_BITS-1:0]   limit_ff, limit_in;
   logic signed [SB-1:0]             span_ff, span_in;
   logic signed [FB-1:0]             base_ff, base_in;
   logic [EB-1:0]                    marker_ff, marker_in;
   logic [CB-1:0]                    count_ff, count_in;
   logic signed [AB-1:0]             acc_ff, acc_in;
   logic [EB-1:0]                    idx_ff, idx_in;
   logic [ZB-1:0]                    steps_ff, steps_in;
   logic [RB-1:0]                    frac_ff, frac_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [EB-1:0]                    rsp_sel_ff, rsp_sel_in;
   logic                             rsp_done_ff, rsp_done_in;
   logic [1:0]                       rsp_status_ff, rsp_status_in;

   rws_pkg::ram_ctl_type             ram_ctl;
   logic [FB-1:0]                    rd_data;
   logic [EB-1:0]                    rd_addr;

   logic [ZB-1:0]                    size_eff;
   logic                             accept;
   logic                             span_pos;
   logic [2*RB-1:0]                  prod;
   logic [RB-1:0]                    mul_b;
   logic signed [AB-1:0]             weight;
   logic signed [AB-1:0]             alu_b;
   logic signed [AB-1:0]             alu_out;
   logic                             alu_pos;
   logic [ZB-1:0]                    steps_next;
   logic [CB-1:0]                    count_next;

   // Next entry on the wheel, wrapping at the size
   function automatic logic [EB-1:0] wheel_next(input logic [EB-1:0] m,
                                                input logic [ZB-1:0] size);
      logic [ZB-1:0] inc;
      inc = {1'b0, m} + {{(ZB-1){1'b0}}, 1'b1};
      return (inc >= size) ? '0 : inc[EB-1:0];
   endfunction

   assign accept   = start && (state_ff == ST_IDLE);
   assign size_eff = (pop_ff > ZB'(rws_pkg::MAX_ENTRIES)) ? ZB'(rws_pkg::MAX_ENTRIES) : pop_ff;
   assign span_pos = !span_ff[SB-1] && (|span_ff);

   // Shared multiplier: low then high word of the span
   assign mul_b = (state_ff == ST_MUL_LO) ? span_ff[RB-1:0]
                                          : {{(RB-8){1'b0}}, span_ff[RB+7:RB]};
   assign prod  = frac_ff * mul_b;

   // Shared accumulator: sum of weights, product add, or walk subtract
   assign weight  = AB'($signed(rd_data)) - AB'(base_ff);
   assign alu_b   = (state_ff == ST_MUL_HI) ? {{(AB-40){1'b0}}, prod[39:0]} : weight;
   assign alu_out = (state_ff == ST_WALK) ? (acc_ff - alu_b) : (acc_ff + alu_b);
   assign alu_pos = !alu_out[AB-1] && (|alu_out);

   assign steps_next = steps_ff + {{(ZB-1){1'b0}}, 1'b1};
   assign count_next = (&count_ff) ? count_ff : (count_ff + {{(CB-1){1'b0}}, 1'b1});

   // Sequencer next state
   always_comb begin
      state_in      = state_ff;
      pop_in        = pop_ff;
      rebased_in    = rebased_ff;
      limit_in      = limit_ff;
      span_in       = span_ff;
      base_in       = base_ff;
      marker_in     = marker_ff;
      count_in      = count_ff;
      acc_in        = acc_ff;
      idx_in        = idx_ff;
      steps_in      = steps_ff;
      frac_in       = frac_ff;
      rsp_valid_in  = 1'b0;
      rsp_sel_in    = '0;
      rsp_done_in   = 1'b0;
      rsp_status_in = rws_pkg::STATUS_OK;
      rd_addr       = idx_ff;

      // Register writes
      if (csr_valid) begin
         unique case (csr_index)
            rws_pkg::CSR_POP_SIZE: pop_in     = csr_data[ZB-1:0];
            rws_pkg::CSR_REBASED:  rebased_in = csr_data[0];
            rws_pkg::CSR_LIMIT:    limit_in   = csr_data;
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_op)
                  rws_pkg::OP_LOAD: begin
                     rsp_valid_in = 1'b1;
                  end
                  rws_pkg::OP_START: begin
                     count_in  = '0;
                     marker_in = ({1'b0, req_start_marker} >= size_eff) ? '0
                                                                        : req_start_marker;
                     base_in   = '0;
                     acc_in    = '0;
                     idx_in    = '0;
                     if (size_eff == '0) begin
                        span_in       = '0;
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = rws_pkg::STATUS_DEGENERATE;
                     end else if (rebased_ff) begin
                        rd_addr  = EB'(size_eff - {{(ZB-1){1'b0}}, 1'b1});
                        state_in = ST_BASE;
                     end else begin
                        rd_addr  = '0;
                        state_in = ST_SUM;
                     end
                  end
                  rws_pkg::OP_SELECT: begin
                     if (size_eff == '0) begin
                        rsp_valid_in  = 1'b1;
                        rsp_done_in   = 1'b1;
                        rsp_status_in = rws_pkg::STATUS_DEGENERATE;
                     end else if (!span_pos) begin
                        rsp_valid_in  = 1'b1;
                        rsp_done_in   = count_ff > CB'(limit_ff);
                        rsp_status_in = rws_pkg::STATUS_DEGENERATE;
                     end else begin
                        frac_in  = req_random_fraction;
                        state_in = ST_MUL_LO;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         ST_BASE: begin
            base_in  = $signed(rd_data);
            rd_addr  = '0;
            state_in = ST_SUM;
         end
         ST_SUM: begin
            acc_in  = alu_out;
            idx_in  = idx_ff + {{(EB-1){1'b0}}, 1'b1};
            rd_addr = idx_in;
            if ({1'b0, idx_ff} == (size_eff - {{(ZB-1){1'b0}}, 1'b1})) begin
               span_in       = alu_out[SB-1:0];
               rsp_valid_in  = 1'b1;
               rsp_status_in = alu_pos ? rws_pkg::STATUS_OK : rws_pkg::STATUS_DEGENERATE;
               state_in      = ST_IDLE;
            end
         end
         ST_MUL_LO: begin
            acc_in   = {{(AB-RB){1'b0}}, prod[2*RB-1:RB]};
            state_in = ST_MUL_HI;
         end
         ST_MUL_HI: begin
            acc_in   = alu_out;
            idx_in   = wheel_next(marker_ff, size_eff);
            rd_addr  = idx_in;
            steps_in = '0;
            state_in = ST_WALK;
         end
         ST_WALK: begin
            if (alu_pos && (steps_next < size_eff)) begin
               acc_in   = alu_out;
               steps_in = steps_next;
               idx_in   = wheel_next(idx_ff, size_eff);
               rd_addr  = idx_in;
            end else begin
               marker_in     = idx_ff;
               count_in      = count_next;
               rsp_valid_in  = 1'b1;
               rsp_sel_in    = idx_ff;
               rsp_done_in   = count_next > CB'(limit_ff);
               rsp_status_in = alu_pos ? rws_pkg::STATUS_LAP : rws_pkg::STATUS_OK;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         pop_ff        <= ZB'(1);
         rebased_ff    <= 1'b0;
         limit_ff      <= '0;
         span_ff       <= '0;
         base_ff       <= '0;
         marker_ff     <= '0;
         count_ff      <= '0;
         steps_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
         rsp_sel_ff    <= '0;
         rsp_done_ff   <= 1'b0;
         rsp_status_ff <= rws_pkg::STATUS_OK;
      end else begin
         state_ff      <= state_in;
         pop_ff        <= pop_in;
         rebased_ff    <= rebased_in;
         limit_ff      <= limit_in;
         span_ff       <= span_in;
         base_ff       <= base_in;
         marker_ff     <= marker_in;
         count_ff      <= count_in;
         steps_ff      <= steps_in;
         rsp_valid_ff  <= rsp_valid_in;
         rsp_sel_ff    <= rsp_sel_in;
         rsp_done_ff   <= rsp_done_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      acc_ff  <= acc_in;
      idx_ff  <= idx_in;
      frac_ff <= frac_in;
   end

   // Fitness table
   assign ram_ctl.wr_en   = accept && (req_op == rws_pkg::OP_LOAD);
   assign ram_ctl.wr_addr = req_entry_index;
   assign ram_ctl.rd_addr = rd_addr;

   rws_fitness_ram u_table (
      .clock   (clock),
      .ctl     (ram_ctl),
      .wr_data (req_fitness_value),
      .rd_data (rd_data)
   );

   assign busy               = (state_ff != ST_IDLE);
   assign csr_ready          = 1'b1;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_selected_index = rsp_sel_ff;
   assign rsp_done_res       = rsp_done_ff;
   assign rsp_status         = rsp_status_ff;

   // Checks
   `ASSERT_IMPLIES(a_rsp_when_idle, clock, reset, rsp_valid, !busy, "response while busy")
   `ASSERT_IMPLIES(a_rsp_has_cause, clock, reset, rsp_valid,
      ($past(busy) || $past(start)), "response without a request")
   `ASSERT_IMPLIES(a_walk_bounded, clock, reset, (state_ff == ST_WALK),
      (steps_ff < size_eff), "walk ran past one lap")
   `ASSERT_ALWAYS(a_status_code, clock, reset,
      ((rsp_status_ff == rws_pkg::STATUS_OK) || (rsp_status_ff == rws_pkg::STATUS_DEGENERATE) ||
       (rsp_status_ff == rws_pkg::STATUS_LAP)), "undefined status code")

endmodule

[bench/roulette_wheel_selector_top_test.sv]
`timescale 1ns / 1ps

module roulette_wheel_selector_top_test;

   localparam int HALF_PERIOD = 5;
   localparam int RANDOM_ITEMS = 1850;
   localparam int NE = rws_pkg::MAX_ENTRIES;
   localparam int EB = rws_pkg::ENTRY_BITS;
   localparam int FB = rws_pkg::FITNESS_BITS;
   localparam int RB = rws_pkg::RANDOM_BITS;
   localparam int ZB = rws_pkg::SIZE_BITS;
   localparam int IB = rws_pkg::CSR_IDX_BITS;
   localparam int DB = rws_pkg::CSR_DAT_BITS;
   localparam int unsigned COUNT_MAX = (1 << rws_pkg::COUNT_BITS) - 1;

   // Codes the package leaves unnamed
   localparam logic [1:0] OP_IGNORED = 2'd3;
   localparam logic [IB-1:0] CSR_UNUSED = 2'd3;

   typedef struct packed {
      logic [EB-1:0] sel;
      logic          done;
      logic [1:0]    status;
   } pick_type;

   typedef enum logic {ROW_REQ, ROW_CSR} row_kind_type;

   // One line of the directed stimulus
   typedef struct {
      row_kind_type          kind;
      logic [1:0]            op;
      logic [EB-1:0]         idx;
      logic signed [FB-1:0]  fit;
      logic [RB-1:0]         frac;
      logic [EB-1:0]         mark;
      logic [IB-1:0]         csr_idx;
      logic [DB-1:0]         csr_dat;
      bit                    has_want;
      pick_type              want;
   } row_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  start;
   logic                  busy;
   logic [1:0]            req_op;
   logic [EB-1:0]         req_entry_index;
   logic signed [FB-1:0]  req_fitness_value;
   logic [RB-1:0]         req_random_fraction;
   logic [EB-1:0]         req_start_marker;
   logic                  rsp_valid;
   logic [EB-1:0]         rsp_selected_index;
   logic                  rsp_done_res;
   logic [1:0]            rsp_status;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [IB-1:0]         csr_index;
   logic [DB-1:0]         csr_data;

   roulette_wheel_selector_top dut (.*);

   always #HALF_PERIOD clock = ~clock;

   // Shadow of the wheel state and registers
   bit signed [FB-1:0] fit_tab [NE];
   bit          loaded [NE];
   longint      wheel_span;
   longint      base_fit;
   int unsigned wheel_pos;
   int unsigned pick_count;
   int unsigned pop_size;
   bit          rebased;
   int unsigned sel_limit;

   pick_type expected_picks [$];
   row_type  dir_rows [$];

   int  err_count, checked, n_items, n_select, n_lap, n_degen, n_start, n_load, n_phase;
   bit  no_idle;

   function automatic int unsigned eff_pop();
      return (pop_size > NE) ? NE : pop_size;
   endfunction

   // Advance the shadow wheel by one request and return the response it should give
   function automatic pick_type compute_pick(logic [1:0] op, logic [EB-1:0] idx,
                                             logic signed [FB-1:0] fit,
                                             logic [RB-1:0] frac,
                                             logic [EB-1:0] mark);
      pick_type        p;
      int unsigned     size, i, steps, m;
      longint          sum, rem;
      longint unsigned f, sp, hi, lo;
      p.sel = '0;
      p.done = 1'b0;
      p.status = rws_pkg::STATUS_OK;
      size = eff_pop();
      case (op)
         rws_pkg::OP_LOAD: begin
            fit_tab[idx] = fit;
            loaded[idx] = 1'b1;
            n_load++;
         end
         rws_pkg::OP_START: begin
            n_start++;
            pick_count = 0;
            wheel_pos = (mark >= size) ? 0 : mark;
            base_fit = 0;
            sum = 0;
            for (i = 0; i < size; i++)
               sum += longint'(fit_tab[i]);
            if (rebased && size > 0) begin
               base_fit = longint'(fit_tab[size-1]);
               sum -= base_fit * longint'(size);
            end
            wheel_span = sum;
            p.status = (wheel_span <= 0) ? rws_pkg::STATUS_DEGENERATE : rws_pkg::STATUS_OK;
         end
         rws_pkg::OP_SELECT: begin
            n_select++;
            if (size == 0 || wheel_span <= 0) begin
               n_degen++;
               p.status = rws_pkg::STATUS_DEGENERATE;
               p.done = (size == 0) ? 1'b1 : (pick_count > sel_limit);
            end else begin
               // remainder = floor(fraction * span / 2^32), split to stay in 64 bits
               f = frac;
               sp = wheel_span;
               hi = sp >> 32;
               lo = sp & 64'hFFFF_FFFF;
               rem = longint'((f * hi) + ((f * lo) >> 32));
               steps = 0;
               m = wheel_pos;
               do begin
                  m++;
                  if (m >= size) m = 0;
                  rem -= longint'(fit_tab[m]) - base_fit;
                  steps++;
               end while (rem > 0 && steps < size);
               if (rem > 0) begin
                  p.status = rws_pkg::STATUS_LAP;
                  n_lap++;
               end
               wheel_pos = m;
               p.sel = m[EB-1:0];
               if (pick_count < COUNT_MAX) pick_count++;
               p.done = (pick_count > sel_limit);
            end
         end
         default: ;
      endcase
      return p;
   endfunction

   function automatic void flag_error(string msg);
      err_count++;
      if (err_count <= 10) $display("%s", msg);
   endfunction

   function automatic row_type mk_req(logic [1:0] op, logic [EB-1:0] idx,
                                      logic signed [FB-1:0] fit,
                                      logic [RB-1:0] frac, logic [EB-1:0] mark);
      row_type row;
      row.kind = ROW_REQ;
      row.op = op;
      row.idx = idx;
      row.fit = fit;
      row.frac = frac;
      row.mark = mark;
      row.csr_idx = rws_pkg::CSR_POP_SIZE;
      row.csr_dat = '0;
      row.has_want = 1'b0;
      row.want = '0;
      return row;
   endfunction

   function automatic row_type mk_typed(logic [1:0] op, logic [EB-1:0] idx,
                                        logic signed [FB-1:0] fit,
                                        logic [RB-1:0] frac, logic [EB-1:0] mark,
                                        logic [EB-1:0] sel, logic done, logic [1:0] status);
      row_type row;
      row = mk_req(op, idx, fit, frac, mark);
      row.has_want = 1'b1;
      row.want.sel = sel;
      row.want.done = done;
      row.want.status = status;
      return row;
   endfunction

   function automatic row_type mk_csr(logic [IB-1:0] idx, logic [DB-1:0] dat);
      row_type row;
      row = mk_req(OP_IGNORED, '0, '0, '0, '0);
      row.kind = ROW_CSR;
      row.csr_idx = idx;
      row.csr_dat = dat;
      return row;
   endfunction

   function automatic logic signed [FB-1:0] fitness_for(int unsigned style);
      case (style)
         0: return $urandom;
         1: return $urandom_range(0, 32'h0003_0000);
         2: return $urandom_range(0, 32'h0004_0000) - 32'h0001_0000;
         default: begin
            case ($urandom_range(0, 3))
               0: return '0;
               1: return 32'h7FFF_FFFF;
               2: return 32'h8000_0000;
               default: return $urandom_range(0, 32'h100);
            endcase
         end
      endcase
   endfunction

   function automatic logic [RB-1:0] frac_pick();
      case ($urandom_range(0, 19))
         0: return '0;
         1: return '1;
         default: return $urandom;
      endcase
   endfunction

   // Present one request and hold it until the block takes it
   task automatic send_request(logic [1:0] op, logic [EB-1:0] idx,
                               logic signed [FB-1:0] fit,
                               logic [RB-1:0] frac, logic [EB-1:0] mark,
                               bit has_want, pick_type want);
      pick_type p;
      start <= 1'b1;
      req_op <= op;
      req_entry_index <= idx;
      req_fitness_value <= fit;
      req_random_fraction <= frac;
      req_start_marker <= mark;
      do @(posedge clock); while (busy);
      p = compute_pick(op, idx, fit, frac, mark);
      expected_picks.push_back(has_want ? want : p);
      n_items++;
   endtask

   // Random idle time between requests, mostly short
   task automatic idle_gap();
      int unsigned r, n;
      if (no_idle) return;
      r = $urandom_range(0, 99);
      if (r < 55) n = 0;
      else if (r < 85) n = $urandom_range(1, 3);
      else if (r < 97) n = $urandom_range(4, 12);
      else n = $urandom_range(30, 80);
      if (n != 0) begin
         start <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic issue(logic [1:0] op, logic [EB-1:0] idx,
                        logic signed [FB-1:0] fit,
                        logic [RB-1:0] frac, logic [EB-1:0] mark);
      send_request(op, idx, fit, frac, mark, 1'b0, '0);
      idle_gap();
   endtask

   // Stop sending until every pending response has come back
   task automatic drain_picks();
      start <= 1'b0;
      do @(posedge clock); while (expected_picks.size() != 0 || busy);
   endtask

   task automatic write_csr(logic [IB-1:0] idx, logic [DB-1:0] dat);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= dat;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         rws_pkg::CSR_POP_SIZE: pop_size = dat[ZB-1:0];
         rws_pkg::CSR_REBASED:  rebased = dat[0];
         rws_pkg::CSR_LIMIT:    sel_limit = dat;
         default: ;
      endcase
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Response checker: one strobe, compared against the oldest pending pick
   always @(posedge clock) begin : rsp_check
      pick_type want;
      if (!reset && rsp_valid !== 1'b0) begin
         if (expected_picks.size() == 0) begin
            flag_error($sformatf("unexpected response: idx=%0d done=%0d status=%0d",
                                 rsp_selected_index, rsp_done_res, rsp_status));
         end else begin
            want = expected_picks.pop_front();
            checked++;
            if (rsp_selected_index !== want.sel || rsp_done_res !== want.done ||
                rsp_status !== want.status)
               flag_error($sformatf({"response %0d: expected idx=%0d done=%0d status=%0d,",
                                     " got idx=%0d done=%0d status=%0d"},
                  checked, want.sel, want.done, want.status,
                  rsp_selected_index, rsp_done_res, rsp_status));
         end
      end
   end

   initial begin : watchdog
      #(40_000_000);
      $display("DONE: errors detected");
      $finish;
   end

   initial begin : stimulus
      row_type          row;
      int unsigned      sz, k, len, r, style, n_dir;
      logic [DB-1:0]    d;
      bit               refill;

      reset <= 1'b1;
      start <= 1'b0;
      req_op <= rws_pkg::OP_LOAD;
      req_entry_index <= '0;
      req_fitness_value <= '0;
      req_random_fraction <= '0;
      req_start_marker <= '0;
      csr_valid <= 1'b0;
      csr_index <= rws_pkg::CSR_POP_SIZE;
      csr_data <= '0;
      pop_size = 1;
      rebased = 1'b0;
      sel_limit = 0;
      wheel_span = 0;
      base_fit = 0;
      wheel_pos = 0;
      pick_count = 0;
      no_idle = 1'b0;

      // Directed: reset state, extremes, an empty size, rebasing, lap overrun
      dir_rows.push_back(mk_typed(rws_pkg::OP_SELECT, 8'd0, '0, '1, 8'd0,
                                  8'd0, 1'b0, rws_pkg::STATUS_DEGENERATE));
      dir_rows.push_back(mk_typed(OP_IGNORED, 8'hFF, '1, '1, 8'hFF,
                                  8'd0, 1'b0, rws_pkg::STATUS_OK));
      dir_rows.push_back(mk_typed(rws_pkg::OP_LOAD, 8'd0, 32'h7FFF_FFFF, '0, 8'd0,
                                  8'd0, 1'b0, rws_pkg::STATUS_OK));
      dir_rows.push_back(mk_typed(rws_pkg::OP_LOAD, 8'hFF, 32'h8000_0000, '1, 8'hFF,
                                  8'd0, 1'b0, rws_pkg::STATUS_OK));
      // marker past the size wraps to zero
      dir_rows.push_back(mk_typed(rws_pkg::OP_START, 8'd0, '0, '0, 8'hFF,
                                  8'd0, 1'b0, rws_pkg::STATUS_OK));
      dir_rows.push_back(mk_typed(rws_pkg::OP_SELECT, 8'd0, '0, '1, 8'd0,
                                  8'd0, 1'b1, rws_pkg::STATUS_OK));
      dir_rows.push_back(mk_typed(rws_pkg::OP_SELECT, 8'd0, '0, '0, 8'd0,
                                  8'd0, 1'b1, rws_pkg::STATUS_OK));
      // size zero, upper data bits set
      dir_rows.push_back(mk_csr(rws_pkg::CSR_POP_SIZE, 16'hFE00));
      dir_rows.push_back(mk_typed(rws_pkg::OP_START, 8'd0, '0, '0, 8'd0,
                                  8'd0, 1'b0, rws_pkg::STATUS_DEGENERATE));
      dir_rows.push_back(mk_typed(rws_pkg::OP_SELECT, 8'd0, '0, '1, 8'd0,
                                  8'd0, 1'b1, rws_pkg::STATUS_DEGENERATE));
      dir_rows.push_back(mk_csr(rws_pkg::CSR_LIMIT, 16'hFFFF));
      dir_rows.push_back(mk_csr(rws_pkg::CSR_POP_SIZE, 16'hA004));
      dir_rows.push_back(mk_typed(rws_pkg::OP_LOAD, 8'd1, 32'h8000_0000, '0, 8'd0,
                                  8'd0, 1'b0, rws_pkg::STATUS_OK));
      dir_rows.push_back(mk_typed(rws_pkg::OP_LOAD, 8'd2, 32'h0001_0000, '0, 8'd0,
                                  8'd0, 1'b0, rws_pkg::STATUS_OK));
      dir_rows.push_back(mk_typed(rws_pkg::OP_LOAD, 8'd3, 32'h8000_0000, '0, 8'd0,
                                  8'd0, 1'b0, rws_pkg::STATUS_OK));
      // negative total without rebasing
      dir_rows.push_back(mk_typed(rws_pkg::OP_START, 8'd0, '0, '0, 8'd2,
                                  8'd0, 1'b0, rws_pkg::STATUS_DEGENERATE));
      dir_rows.push_back(mk_typed(rws_pkg::OP_SELECT, 8'd0, '0, '1, 8'd0,
                                  8'd0, 1'b0, rws_pkg::STATUS_DEGENERATE));
      dir_rows.push_back(mk_csr(rws_pkg::CSR_REBASED, 16'h0001));
      dir_rows.push_back(mk_typed(rws_pkg::OP_START, 8'd0, '0, '0, 8'd2,
                                  8'd0, 1'b0, rws_pkg::STATUS_OK));
      dir_rows.push_back(mk_req(rws_pkg::OP_SELECT, 8'd0, '0, 32'h8000_0000, 8'd0));
      dir_rows.push_back(mk_req(rws_pkg::OP_SELECT, 8'd0, '0, '1, 8'd0));
      dir_rows.push_back(mk_req(rws_pkg::OP_SELECT, 8'd0, '0, '0, 8'd0));
      // flatten the table after the start so the walk runs a full lap
      dir_rows.push_back(mk_typed(rws_pkg::OP_LOAD, 8'd0, 32'h8000_0000, '0, 8'd0,
                                  8'd0, 1'b0, rws_pkg::STATUS_OK));
      dir_rows.push_back(mk_typed(rws_pkg::OP_LOAD, 8'd2, 32'h8000_0000, '0, 8'd0,
                                  8'd0, 1'b0, rws_pkg::STATUS_OK));
      dir_rows.push_back(mk_req(rws_pkg::OP_SELECT, 8'd0, '0, '1, 8'd0));
      dir_rows.push_back(mk_csr(CSR_UNUSED, 16'h5A5A));
      dir_rows.push_back(mk_csr(rws_pkg::CSR_REBASED, 16'hFFFE));
      dir_rows.push_back(mk_typed(rws_pkg::OP_START, 8'd0, '0, '0, 8'd2,
                                  8'd0, 1'b0, rws_pkg::STATUS_DEGENERATE));
      dir_rows.push_back(mk_typed(rws_pkg::OP_SELECT, 8'd0, '0, '1, 8'd0,
                                  8'd0, 1'b0, rws_pkg::STATUS_DEGENERATE));

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) begin
         row = dir_rows[i];
         if (row.kind == ROW_CSR) begin
            drain_picks();
            write_csr(row.csr_idx, row.csr_dat);
         end else begin
            send_request(row.op, row.idx, row.fit, row.frac, row.mark, row.has_want, row.want);
            idle_gap();
         end
      end
      n_dir = n_items;

      // Random phases: new registers, fill the table, usually start, then mostly selects
      while (n_items < n_dir + RANDOM_ITEMS) begin
         drain_picks();
         n_phase++;
         r = $urandom_range(0, 99);
         if (r < 70) sz = $urandom_range(1, 16);
         else if (r < 80) sz = $urandom_range(17, 64);
         else if (r < 85) sz = $urandom_range(65, NE - 1);
         else if (r < 91) sz = NE;
         else if (r < 96) sz = $urandom_range(NE + 1, 511);
         else sz = 0;
         d = 16'($urandom);
         d[ZB-1:0] = sz[ZB-1:0];
         write_csr(rws_pkg::CSR_POP_SIZE, d);
         write_csr(rws_pkg::CSR_REBASED, 16'($urandom));
         r = $urandom_range(0, 99);
         if (r < 15) d = '0;
         else if (r < 25) d = '1;
         else d = 16'($urandom_range(0, 40));
         write_csr(rws_pkg::CSR_LIMIT, d);
         if ($urandom_range(0, 19) == 0) write_csr(CSR_UNUSED, 16'($urandom));

         style = $urandom_range(0, 3);
         no_idle = ($urandom_range(0, 3) == 0);
         refill = (eff_pop() <= 32) && ($urandom_range(0, 1) == 1);
         // every entry the wheel can reach must hold a value
         for (k = 0; k < eff_pop(); k++)
            if (!loaded[k] || refill)
               issue(rws_pkg::OP_LOAD, k[EB-1:0], fitness_for(style), $urandom, 8'($urandom));
         if ($urandom_range(0, 9) != 0)
            issue(rws_pkg::OP_START, 8'($urandom), $urandom, $urandom, 8'($urandom));

         len = $urandom_range(15, 50);
         repeat (len) begin
            r = $urandom_range(0, 99);
            if (r < 72)
               issue(rws_pkg::OP_SELECT, 8'($urandom), $urandom, frac_pick(), 8'($urandom));
            else if (r < 84)
               issue(rws_pkg::OP_LOAD, 8'($urandom),
                     ($urandom_range(0, 4) == 0) ? '0 : fitness_for(style),
                     $urandom, 8'($urandom));
            else if (r < 92)
               issue(rws_pkg::OP_START, 8'($urandom), $urandom, $urandom, 8'($urandom));
            else if (r < 96)
               issue(OP_IGNORED, 8'($urandom), $urandom, $urandom, 8'($urandom));
            else
               drain_picks();
         end
      end

      drain_picks();
      repeat (300) @(posedge clock);
      if (expected_picks.size() != 0)
         flag_error($sformatf("%0d responses never arrived", expected_picks.size()));

      $display("Sent %0d requests over %0d register phases: %0d loads, %0d starts, %0d selects",
               n_items, n_phase, n_load, n_start, n_select);
      $display("Selects with degenerate span: %0d, past one lap: %0d; responses checked: %0d",
               n_degen, n_lap, checked);
      if (err_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
